// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property check
`define QVR_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// same-cycle implication
`define QVR_ASSERT_IMP(lbl, ante, cons, msg) \
	`QVR_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

// File: sv/qvr_pkg.sv
// ----------------------------------------------------------------------------
// qvr_pkg
// Types and constants shared by the quaternion vector rotation unit.
// ----------------------------------------------------------------------------
package qvr_pkg;

	localparam int unsigned DATA_W      = 32;
	localparam int unsigned UNIT_SHIFT  = 30;               // unit quaternion is Q2.30
	localparam int unsigned MAG_W       = 31;               // normalized magnitude
	localparam int unsigned SQ_W        = 2 * MAG_W;        // squared magnitude
	localparam int unsigned N2_W        = 64;               // sum of squares
	localparam int unsigned ROOT_W      = 32;
	localparam int unsigned NUM_W       = MAG_W + UNIT_SHIFT + 1;
	localparam int unsigned QUO_W       = 31;
	localparam int unsigned SQRT_STEPS  = 32;
	localparam int unsigned DIV_STEPS   = QUO_W;
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned PTR_W       = $clog2(QUEUE_DEPTH);
	localparam int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int unsigned PA_W        = 2 * DATA_W;       // u * v
	localparam int unsigned TA_W        = PA_W + 2;         // sum of three
	localparam int unsigned T_W         = 34;               // first product term
	localparam int unsigned PB_W        = T_W + DATA_W;     // t * u
	localparam int unsigned RB_W        = PB_W + 2;         // sum of four
	localparam int unsigned R_W         = 38;               // unclamped result

	typedef struct packed {
		logic signed [DATA_W-1:0] quat_w;
		logic signed [DATA_W-1:0] quat_x;
		logic signed [DATA_W-1:0] quat_y;
		logic signed [DATA_W-1:0] quat_z;
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} qvr_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] rot_x;
		logic signed [DATA_W-1:0] rot_y;
		logic signed [DATA_W-1:0] rot_z;
		logic                     degenerate;
		logic                     saturated;
	} qvr_out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] vec_x;
		logic signed [DATA_W-1:0] vec_y;
		logic signed [DATA_W-1:0] vec_z;
	} qvr_vec_t;

	// what travels alongside the arithmetic in the back end
	typedef struct packed {
		logic [3:0] neg;
		logic       degen;
		qvr_vec_t   vec;
	} qvr_side_t;

	// classified transaction held in the queue
	typedef struct packed {
		logic [3:0][MAG_W-1:0] mag;
		qvr_side_t             side;
	} qvr_item_t;

endpackage

// File: sv/quaternion_vector_rotate_unit.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit
// Rotates a Q16.16 vector by a Q16.16 quaternion that need not be normalized.
// ----------------------------------------------------------------------------
// One rotation is accepted every clock cycle unless item_stall is high, and each
// transaction gives one result. Its path is two front stages, the queue, then
// the back end, whose length is set by the 32-stage square root of the norm
// and the 31-stage dividers that scale each component. A zero quaternion
// returns the vector unchanged with degenerate set; any clamped component
// sets saturated.
`include "assert_macros.svh"

module quaternion_vector_rotate_unit (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  qvr_pkg::qvr_in_t  item,
	output logic              result_valid,
	input  logic              result_stall,
	output qvr_pkg::qvr_out_t result
);
	import qvr_pkg::*;

	logic      push, pop, full, empty;
	qvr_item_t push_data, head;

	// classify and scale
	qvr_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.full       (full),
		.push       (push),
		.push_data  (push_data)
	);

	// decouple front from back
	qvr_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (push_data),
		.pop    (pop),
		.rdata  (head),
		.full   (full),
		.empty  (empty)
	);

	// normalize and rotate
	qvr_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.head_valid   (!empty),
		.pop          (pop),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result)
	);

	`QVR_ASSERT_IMP(a_degen_clean, result_valid && result.degenerate, !result.saturated, "degenerate result flagged saturated")

endmodule

// File: sv/qvr_front.sv
// ----------------------------------------------------------------------------
// qvr_front
// Accepts transactions, takes magnitudes and scales the quaternion so that
// its largest component sits at bit 30, and flags the zero quaternion.
// ----------------------------------------------------------------------------
module qvr_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               item_valid,
	output logic               item_stall,
	input  qvr_pkg::qvr_in_t   item,
	input  logic               full,
	output logic               push,
	output qvr_pkg::qvr_item_t push_data
);
	import qvr_pkg::*;

	logic                   adv;
	logic                   vld_s1, vld_s2;
	logic [3:0][DATA_W-1:0] quat, mag_in;
	logic [3:0][DATA_W-1:0] mag_s1, mag_s2;
	logic [3:0]             neg_s1, neg_s2;
	qvr_vec_t               vec_s1, vec_s2;
	logic [DATA_W-1:0]      m01, m23, mx, m_s2;
	logic [4:0]             lead, shl;
	logic [3:0][DATA_W-1:0] shifted;

	// both stages move together whenever the last one can drain
	assign adv        = !vld_s2 || !full;
	assign item_stall = !adv;
	assign push       = vld_s2 && !full;

	// magnitudes, index 0 is the scalar part
	assign quat = {item.quat_z, item.quat_y, item.quat_x, item.quat_w};
	always_comb begin
		for (int i = 0; i < 4; i++) begin
			mag_in[i] = quat[i][DATA_W-1] ? (~quat[i] + 1'b1) : quat[i];
		end
	end

	// largest magnitude
	always_comb begin
		m01 = (mag_s1[0] > mag_s1[1]) ? mag_s1[0] : mag_s1[1];
		m23 = (mag_s1[2] > mag_s1[3]) ? mag_s1[2] : mag_s1[3];
		mx  = (m01 > m23) ? m01 : m23;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= item_valid;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			mag_s1 <= mag_in;
			neg_s1 <= {item.quat_z[DATA_W-1], item.quat_y[DATA_W-1],
				item.quat_x[DATA_W-1], item.quat_w[DATA_W-1]};
			vec_s1 <= '{vec_x: item.vec_x, vec_y: item.vec_y, vec_z: item.vec_z};
			mag_s2 <= mag_s1;
			neg_s2 <= neg_s1;
			vec_s2 <= vec_s1;
			m_s2   <= mx;
		end
	end

	// leading zero count; shift left brings the top bit to bit 30
	always_comb begin
		lead = '0;
		for (int i = 0; i < DATA_W; i++) begin
			if (m_s2[i]) lead = 5'(DATA_W - 1 - i);
		end
		shl = lead - 5'd1;
		for (int i = 0; i < 4; i++) begin
			shifted[i] = mag_s2[i] << shl;
		end
	end

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			push_data.mag[i] = m_s2[DATA_W-1] ? mag_s2[i][DATA_W-1:1] : shifted[i][MAG_W-1:0];
		end
		push_data.side.neg   = neg_s2;
		push_data.side.degen = (m_s2 == '0);
		push_data.side.vec   = vec_s2;
	end

endmodule

// File: sv/qvr_queue.sv
// ----------------------------------------------------------------------------
// qvr_queue
// Short first-in first-out queue between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qvr_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  qvr_pkg::qvr_item_t wdata,
	input  logic               pop,
	output qvr_pkg::qvr_item_t rdata,
	output logic               full,
	output logic               empty
);
	import qvr_pkg::*;

	qvr_item_t        mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(QUEUE_DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop)  rd_q <= (rd_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
			cnt_q <= cnt_q + CNT_W'(push) - CNT_W'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	`QVR_ASSERT(a_cnt_bound, cnt_q <= CNT_W'(QUEUE_DEPTH), "queue count beyond depth")
	`QVR_ASSERT_IMP(a_no_underflow, pop, cnt_q != '0, "pop from empty queue")
	`QVR_ASSERT(a_cnt_track, cnt_q == $past(cnt_q) + CNT_W'($past(push)) - CNT_W'($past(pop)), "queue count lost a transaction")

endmodule

// File: sv/qvr_sqrt.sv
// ----------------------------------------------------------------------------
// qvr_sqrt
// Pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module qvr_sqrt (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qvr_pkg::N2_W-1:0]   radicand,
	output logic [qvr_pkg::ROOT_W-1:0] root
);
	import qvr_pkg::*;

	logic [N2_W-1:0] rem_q [SQRT_STEPS];
	logic [N2_W-1:0] res_q [SQRT_STEPS];

	for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
		localparam logic [N2_W-1:0] BIT = N2_W'(1) << (N2_W - 2 - 2 * k);
		logic [N2_W-1:0] rem_in, res_in, trial;

		if (k == 0) begin : g_first
			assign rem_in = radicand;
			assign res_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign res_in = res_q[k-1];
		end

		assign trial = res_in + BIT;

		always_ff @(posedge clk) begin
			if (en) begin
				if (rem_in >= trial) begin
					rem_q[k] <= rem_in - trial;
					res_q[k] <= (res_in >> 1) + BIT;
				end else begin
					rem_q[k] <= rem_in;
					res_q[k] <= res_in >> 1;
				end
			end
		end
	end

	assign root = res_q[SQRT_STEPS-1][ROOT_W-1:0];

endmodule

// File: sv/qvr_div.sv
// ----------------------------------------------------------------------------
// qvr_div
// Pipelined restoring divider, one quotient bit per stage.
// ----------------------------------------------------------------------------
module qvr_div (
	input  logic                       clk,
	input  logic                       en,
	input  logic [qvr_pkg::NUM_W-1:0]  num,
	input  logic [qvr_pkg::ROOT_W-1:0] den,
	output logic [qvr_pkg::QUO_W-1:0]  quo
);
	import qvr_pkg::*;

	logic [ROOT_W-1:0] rem_q [DIV_STEPS];
	logic [QUO_W-1:0]  low_q [DIV_STEPS];
	logic [QUO_W-1:0]  quo_q [DIV_STEPS];
	logic [ROOT_W-1:0] den_q [DIV_STEPS];

	for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
		logic [ROOT_W-1:0] rem_in, den_in;
		logic [QUO_W-1:0]  low_in, quo_in;
		logic [ROOT_W:0]   shifted, diff;
		logic              ge;

		if (k == 0) begin : g_first
			// upper bits are known to be below the divisor
			assign rem_in = ROOT_W'(num[NUM_W-1:QUO_W]);
			assign low_in = num[QUO_W-1:0];
			assign den_in = den;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_q[k-1];
			assign low_in = low_q[k-1];
			assign den_in = den_q[k-1];
			assign quo_in = quo_q[k-1];
		end

		assign shifted = {rem_in, low_in[QUO_W-1]};
		assign ge      = (shifted >= {1'b0, den_in});
		assign diff    = shifted - {1'b0, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[k] <= ge ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
				low_q[k] <= {low_in[QUO_W-2:0], 1'b0};
				quo_q[k] <= {quo_in[QUO_W-2:0], ge};
				den_q[k] <= den_in;
			end
		end
	end

	assign quo = quo_q[DIV_STEPS-1];

endmodule

// File: sv/qvr_back.sv
// ----------------------------------------------------------------------------
// qvr_back
// Normalizes the quaternion, forms u * p * conj(u) and clamps the result.
// ----------------------------------------------------------------------------
module qvr_back (
	input  logic               clk,
	input  logic               arst_n,
	input  qvr_pkg::qvr_item_t head,
	input  logic               head_valid,
	output logic               pop,
	output logic               result_valid,
	input  logic               result_stall,
	output qvr_pkg::qvr_out_t  result
);
	import qvr_pkg::*;

	localparam logic signed [TA_W-1:0] RND_A = TA_W'(1) << (UNIT_SHIFT - 1);
	localparam logic signed [RB_W-1:0] RND_B = RB_W'(1) << (UNIT_SHIFT - 1);
	localparam logic signed [R_W-1:0]  R_MAX = {{(R_W-DATA_W+1){1'b0}}, {(DATA_W-1){1'b1}}};
	localparam logic signed [R_W-1:0]  R_MIN = {{(R_W-DATA_W+1){1'b1}}, {(DATA_W-1){1'b0}}};

	logic en;

	logic                   vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8;
	logic [SQRT_STEPS-1:0]  vld_sq;
	logic [DIV_STEPS-1:0]   vld_dv;
	logic                   result_valid_q;
	qvr_out_t               result_q, result_d;

	logic [SQ_W-1:0]        sq_s1 [4];
	logic [3:0][MAG_W-1:0]  mag_s1, mag_s2;
	logic [3:0][MAG_W-1:0]  mag_sq [SQRT_STEPS];
	qvr_side_t              side_s1, side_s2, side_s3, side_s4, side_s5, side_s6, side_s7, side_s8;
	qvr_side_t              side_sq [SQRT_STEPS];
	qvr_side_t              side_dv [DIV_STEPS];
	logic [N2_W-1:0]        n2_s2;
	logic [ROOT_W-1:0]      root, root_s3;
	logic [NUM_W-1:0]       num_s3 [4];
	logic [QUO_W-1:0]       quo [4];
	logic signed [DATA_W-1:0] u_s4 [4], u_s5 [4], u_s6 [4];
	logic signed [DATA_W-1:0] vv [3];
	logic signed [PA_W-1:0] pa_s5 [4][3];
	logic signed [TA_W-1:0] ta [4];
	logic signed [T_W-1:0]  t_s6 [4];
	logic signed [PB_W-1:0] pb_s7 [12];
	logic signed [RB_W-1:0] rb [3];
	logic signed [R_W-1:0]  r_s8 [3];
	logic signed [DATA_W-1:0] rot [3];
	logic [2:0]             clip;

	// the whole back end advances when the output register can load
	assign en           = !result_valid_q || !result_stall;
	assign pop          = en && head_valid;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1         <= 1'b0;
			vld_s2         <= 1'b0;
			vld_sq         <= '0;
			vld_s3         <= 1'b0;
			vld_dv         <= '0;
			vld_s4         <= 1'b0;
			vld_s5         <= 1'b0;
			vld_s6         <= 1'b0;
			vld_s7         <= 1'b0;
			vld_s8         <= 1'b0;
			result_valid_q <= 1'b0;
		end else if (en) begin
			vld_s1         <= head_valid;
			vld_s2         <= vld_s1;
			vld_sq         <= {vld_sq[SQRT_STEPS-2:0], vld_s2};
			vld_s3         <= vld_sq[SQRT_STEPS-1];
			vld_dv         <= {vld_dv[DIV_STEPS-2:0], vld_s3};
			vld_s4         <= vld_dv[DIV_STEPS-1];
			vld_s5         <= vld_s4;
			vld_s6         <= vld_s5;
			vld_s7         <= vld_s6;
			vld_s8         <= vld_s7;
			result_valid_q <= vld_s8;
		end
	end

	// squares and their sum
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				sq_s1[i] <= SQ_W'(head.mag[i]) * SQ_W'(head.mag[i]);
			end
			mag_s1  <= head.mag;
			side_s1 <= head.side;
			n2_s2   <= N2_W'(sq_s1[0]) + N2_W'(sq_s1[1]) + N2_W'(sq_s1[2]) + N2_W'(sq_s1[3]);
			mag_s2  <= mag_s1;
			side_s2 <= side_s1;
		end
	end

	qvr_sqrt u_sqrt (
		.clk      (clk),
		.en       (en),
		.radicand (n2_s2),
		.root     (root)
	);

	// side data follows the square root
	always_ff @(posedge clk) begin
		if (en) begin
			mag_sq[0]  <= mag_s2;
			side_sq[0] <= side_s2;
			for (int k = 1; k < SQRT_STEPS; k++) begin
				mag_sq[k]  <= mag_sq[k-1];
				side_sq[k] <= side_sq[k-1];
			end
		end
	end

	// rounded numerators for the four divisions
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				num_s3[i] <= (NUM_W'(mag_sq[SQRT_STEPS-1][i]) << UNIT_SHIFT)
					+ NUM_W'(root >> 1);
			end
			root_s3 <= root;
			side_s3 <= side_sq[SQRT_STEPS-1];
		end
	end

	for (genvar i = 0; i < 4; i++) begin : g_div
		qvr_div u_div (
			.clk (clk),
			.en  (en),
			.num (num_s3[i]),
			.den (root_s3),
			.quo (quo[i])
		);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_dv[0] <= side_s3;
			for (int k = 1; k < DIV_STEPS; k++) begin
				side_dv[k] <= side_dv[k-1];
			end
		end
	end

	// signed unit quaternion
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				u_s4[i] <= side_dv[DIV_STEPS-1].neg[i] ? -$signed({1'b0, quo[i]})
					: $signed({1'b0, quo[i]});
			end
			side_s4 <= side_dv[DIV_STEPS-1];
		end
	end

	// first product: u * (0, v)
	assign vv[0] = side_s4.vec.vec_x;
	assign vv[1] = side_s4.vec.vec_y;
	assign vv[2] = side_s4.vec.vec_z;

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				for (int j = 0; j < 3; j++) begin
					pa_s5[i][j] <= u_s4[i] * vv[j];
				end
			end
			u_s5    <= u_s4;
			side_s5 <= side_s4;
		end
	end

	always_comb begin
		ta[0] = RND_A - pa_s5[1][0] - pa_s5[2][1] - pa_s5[3][2];
		ta[1] = RND_A + pa_s5[0][0] + pa_s5[2][2] - pa_s5[3][1];
		ta[2] = RND_A + pa_s5[0][1] - pa_s5[1][2] + pa_s5[3][0];
		ta[3] = RND_A + pa_s5[0][2] + pa_s5[1][1] - pa_s5[2][0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 4; i++) begin
				t_s6[i] <= T_W'(ta[i] >>> UNIT_SHIFT);
			end
			u_s6    <= u_s5;
			side_s6 <= side_s5;
		end
	end

	// second product: vector part of t * conj(u)
	always_ff @(posedge clk) begin
		if (en) begin
			pb_s7[0]  <= t_s6[0] * u_s6[1];
			pb_s7[1]  <= t_s6[0] * u_s6[2];
			pb_s7[2]  <= t_s6[0] * u_s6[3];
			pb_s7[3]  <= t_s6[1] * u_s6[0];
			pb_s7[4]  <= t_s6[1] * u_s6[2];
			pb_s7[5]  <= t_s6[1] * u_s6[3];
			pb_s7[6]  <= t_s6[2] * u_s6[0];
			pb_s7[7]  <= t_s6[2] * u_s6[1];
			pb_s7[8]  <= t_s6[2] * u_s6[3];
			pb_s7[9]  <= t_s6[3] * u_s6[0];
			pb_s7[10] <= t_s6[3] * u_s6[1];
			pb_s7[11] <= t_s6[3] * u_s6[2];
			side_s7   <= side_s6;
		end
	end

	always_comb begin
		rb[0] = RND_B - pb_s7[0] + pb_s7[3] - pb_s7[8] + pb_s7[11];
		rb[1] = RND_B - pb_s7[1] + pb_s7[5] + pb_s7[6] - pb_s7[10];
		rb[2] = RND_B - pb_s7[2] - pb_s7[4] + pb_s7[7] + pb_s7[9];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				r_s8[i] <= R_W'(rb[i] >>> UNIT_SHIFT);
			end
			side_s8 <= side_s7;
		end
	end

	// clamp, or pass the vector through for the zero quaternion
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			clip[i] = 1'b1;
			if (r_s8[i] > R_MAX)      rot[i] = R_MAX[DATA_W-1:0];
			else if (r_s8[i] < R_MIN) rot[i] = R_MIN[DATA_W-1:0];
			else begin
				rot[i]  = r_s8[i][DATA_W-1:0];
				clip[i] = 1'b0;
			end
		end
		if (side_s8.degen) begin
			result_d.rot_x      = side_s8.vec.vec_x;
			result_d.rot_y      = side_s8.vec.vec_y;
			result_d.rot_z      = side_s8.vec.vec_z;
			result_d.degenerate = 1'b1;
			result_d.saturated  = 1'b0;
		end else begin
			result_d.rot_x      = rot[0];
			result_d.rot_y      = rot[1];
			result_d.rot_z      = rot[2];
			result_d.degenerate = 1'b0;
			result_d.saturated  = |clip;
		end
	end

	always_ff @(posedge clk) begin
		if (en) result_q <= result_d;
	end

endmodule

// File: tb/quaternion_vector_rotate_unit_tb.sv
// ----------------------------------------------------------------------------
// quaternion_vector_rotate_unit_tb
// Drives rotations through the unit under random flow control and compares
// every result with a bit-exact fixed-point rotation computed in the bench.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate_unit_tb;
	import qvr_pkg::*;

	localparam int LATENCY = 74;

	logic     clk;
	logic     arst_n;
	logic     item_valid;
	logic     item_stall;
	qvr_in_t  item;
	logic     result_valid;
	logic     result_stall;
	qvr_out_t result;

	qvr_out_t rotations_due[$];
	int       mismatches;
	int       checked;
	int       degenerate_seen;
	int       saturated_seen;
	int       send_idle_pct;
	int       recv_idle_pct;
	int       hold_cycles;

	quaternion_vector_rotate_unit i_dut (
		.clk(clk), .arst_n(arst_n),
		.item_valid(item_valid), .item_stall(item_stall), .item(item),
		.result_valid(result_valid), .result_stall(result_stall), .result(result)
	);

	always begin
		clk = 1'b0; #10;
		clk = 1'b1; #10;
	end

	// rounding of a Q2.30 product sum, floor((s + 2^29) / 2^30)
	function automatic longint round_q30(longint s);
		return (s + (64'sd1 <<< 29)) >>> UNIT_SHIFT;
	endfunction

	function automatic logic [63:0] root_floor(logic [63:0] n);
		logic [63:0] acc, bitv;
		acc = 0;
		bitv = 64'd1 << 62;
		while (bitv > n) bitv >>= 2;
		while (bitv != 0) begin
			if (n >= acc + bitv) begin
				n -= acc + bitv;
				acc = (acc >> 1) + bitv;
			end else begin
				acc >>= 1;
			end
			bitv >>= 2;
		end
		return acc;
	endfunction

	// expected rotation of one transaction
	function automatic qvr_out_t rotate_vector(qvr_in_t d);
		longint      q[4], v[3], u[4], t[4], r[3];
		logic [63:0] a[4], peak, n2, rt, mag;
		qvr_out_t    o;
		longint      lim_hi, lim_lo;
		int          sh;
		lim_hi = 64'sd2147483647;
		lim_lo = -64'sd2147483648;
		q[0] = d.quat_w; q[1] = d.quat_x; q[2] = d.quat_y; q[3] = d.quat_z;
		v[0] = d.vec_x; v[1] = d.vec_y; v[2] = d.vec_z;
		o = '0;
		peak = 0;
		for (int i = 0; i < 4; i++) begin
			a[i] = q[i] < 0 ? -q[i] : q[i];
			if (a[i] > peak) peak = a[i];
		end
		if (peak == 0) begin
			o.rot_x = d.vec_x; o.rot_y = d.vec_y; o.rot_z = d.vec_z;
			o.degenerate = 1'b1;
			return o;
		end
		if (peak >= 64'd1 << 31) begin
			for (int i = 0; i < 4; i++) a[i] >>= 1;
		end else begin
			sh = 0;
			while ((peak << sh) < (64'd1 << 30)) sh++;
			for (int i = 0; i < 4; i++) a[i] <<= sh;
		end
		n2 = 0;
		for (int i = 0; i < 4; i++) n2 += a[i] * a[i];
		rt = root_floor(n2);
		for (int i = 0; i < 4; i++) begin
			mag = ((a[i] << UNIT_SHIFT) + (rt >> 1)) / rt;
			u[i] = q[i] < 0 ? -longint'(mag) : longint'(mag);
		end
		t[0] = round_q30(-u[1]*v[0] - u[2]*v[1] - u[3]*v[2]);
		t[1] = round_q30(u[0]*v[0] + u[2]*v[2] - u[3]*v[1]);
		t[2] = round_q30(u[0]*v[1] - u[1]*v[2] + u[3]*v[0]);
		t[3] = round_q30(u[0]*v[2] + u[1]*v[1] - u[2]*v[0]);
		r[0] = round_q30(-t[0]*u[1] + t[1]*u[0] - t[2]*u[3] + t[3]*u[2]);
		r[1] = round_q30(-t[0]*u[2] + t[1]*u[3] + t[2]*u[0] - t[3]*u[1]);
		r[2] = round_q30(-t[0]*u[3] - t[1]*u[2] + t[2]*u[1] + t[3]*u[0]);
		for (int i = 0; i < 3; i++) begin
			if (r[i] > lim_hi) begin
				r[i] = lim_hi; o.saturated = 1'b1;
			end else if (r[i] < lim_lo) begin
				r[i] = lim_lo; o.saturated = 1'b1;
			end
		end
		o.rot_x = r[0][31:0]; o.rot_y = r[1][31:0]; o.rot_z = r[2][31:0];
		return o;
	endfunction

	// one transaction: offer, wait for acceptance, queue its expected result
	// valid stays high after acceptance so back-to-back offers need no gap
	task automatic send_rotation(qvr_in_t d);
		while ($urandom_range(99) < send_idle_pct) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		item_valid <= 1'b1;
		item       <= d;
		@(posedge clk);
		while (item_stall) @(posedge clk);
		rotations_due.push_back(rotate_vector(d));
	endtask

	// mix of extremes, small values and full random words
	function automatic logic [31:0] pick_word();
		case ($urandom_range(7))
			0: return 32'h8000_0000;
			1: return 32'h7fff_ffff;
			2: return 32'(int'($urandom_range(0, 131072)) - 65536);
			3: return 32'h0;
			4: return $urandom() >> $urandom_range(31);
			default: return $urandom();
		endcase
	endfunction

	function automatic qvr_in_t random_rotation();
		qvr_in_t d;
		d.quat_w = pick_word(); d.quat_x = pick_word();
		d.quat_y = pick_word(); d.quat_z = pick_word();
		d.vec_x  = pick_word(); d.vec_y  = pick_word(); d.vec_z = pick_word();
		// a zero quaternion now and then
		if ($urandom_range(19) == 0) begin
			d.quat_w = 0; d.quat_x = 0; d.quat_y = 0; d.quat_z = 0;
		end
		return d;
	endfunction

	// stop offering and wait for every outstanding result
	task automatic wait_drained();
		item_valid <= 1'b0;
		while (rotations_due.size() != 0) @(posedge clk);
	endtask

	// result checker
	always @(posedge clk) begin
		qvr_out_t want;
		if (arst_n && result_valid && !result_stall) begin
			if (rotations_due.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected result %h", result);
			end else begin
				want = rotations_due.pop_front();
				checked++;
				if (want.degenerate) degenerate_seen++;
				if (want.saturated) saturated_seen++;
				if (result !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected x=%h y=%h z=%h d=%b s=%b, got x=%h y=%h z=%h d=%b s=%b",
							want.rot_x, want.rot_y, want.rot_z, want.degenerate, want.saturated,
							result.rot_x, result.rot_y, result.rot_z, result.degenerate,
							result.saturated);
				end
			end
		end
	end

	// receiver stall: long hold when asked, otherwise random
	always @(posedge clk) begin
		if (hold_cycles > 0) begin
			hold_cycles  <= hold_cycles - 1;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	task automatic test_directed();
		qvr_in_t d;
		logic [31:0] ext[5];
		ext = '{32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000, 32'hffff_ffff, 32'h0};
		// identity, zero quaternion, extremes on each component
		d = '{32'h0001_0000, 0, 0, 0, 32'h0001_0000, 32'h0002_0000, 32'hfffd_0000};
		send_rotation(d);
		d = '{0, 0, 0, 0, 32'h8000_0000, 32'h7fff_ffff, 32'h1234_5678};
		send_rotation(d);
		for (int i = 0; i < 5; i++) begin
			d = '{ext[i], ext[(i+1)%5], ext[(i+2)%5], ext[(i+3)%5],
				ext[(i+4)%5], ext[i], ext[(i+2)%5]};
			send_rotation(d);
		end
		// full-scale quaternion and vector, clamping
		d = '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
			32'h8000_0000, 32'h8000_0000, 32'h8000_0000};
		send_rotation(d);
		d = '{32'h7fff_ffff, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff};
		send_rotation(d);
		// smallest nonzero quaternions, 180 and 90 degrees about z
		d = '{0, 0, 0, 32'h1, 32'h0001_0000, 0, 0};
		send_rotation(d);
		d = '{32'h1, 0, 0, 32'h1, 32'h7fff_ffff, 32'h8000_0000, 32'h5};
		send_rotation(d);
		d = '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff,
			32'hffff_ffff, 32'h0, 32'h1};
		send_rotation(d);
	endtask

	task automatic test_random(int n);
		for (int i = 0; i < n; i++) send_rotation(random_rotation());
	endtask

	// receiver holds off while the sender keeps offering
	task automatic test_backpressure();
		hold_cycles <= 300;
		test_random(120);
		wait_drained();
		test_random(30);
	endtask

	initial begin : run_limit
		#(20 * 600000);
		$display("** quaternion_vector_rotate_unit: FAILED **");
		$finish;
	end

	initial begin : main
		item_valid    = 1'b0;
		item          = '0;
		result_stall  = 1'b0;
		mismatches    = 0;
		checked       = 0;
		degenerate_seen = 0;
		saturated_seen  = 0;
		hold_cycles   = 0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		arst_n        = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		send_idle_pct = 6;  recv_idle_pct = 57;
		test_random(500);
		test_backpressure();
		send_idle_pct = 57; recv_idle_pct = 6;
		test_random(500);
		send_idle_pct = 0;  recv_idle_pct = 0;
		test_random(480);
		wait_drained();
		repeat (LATENCY + 20) @(posedge clk);
		$display("checked %0d rotations (%0d degenerate, %0d clamped) under varied flow control",
			checked, degenerate_seen, saturated_seen);
		if (mismatches == 0 && rotations_due.size() == 0) begin
			$display("** quaternion_vector_rotate_unit: PASSED **");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("** quaternion_vector_rotate_unit: FAILED **");
		end
		$finish;
	end

endmodule
